>>> rtl/core/acfp_pkg.sv
// Shared constants for the ASCII command frame parser and its checker.
// Depends on nothing; imported by every other file of the block.
package acfp_pkg;

	// Longest frame body accepted before the frame is dropped.
	localparam int unsigned MAX_FRAME_CHARS = 32;
	localparam int unsigned CNT_W = $clog2(MAX_FRAME_CHARS + 1);

	// Field widths of one input request and one result.
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned ARG_W   = 32;
	localparam int unsigned OUT_W   = CMD_W + 2 * ARG_W;
	localparam int unsigned OUT_T_W = ((OUT_W + 7) / 8) * 8;

	// Character codes that steer the parser.
	localparam logic [CHAR_W-1:0] CH_START = 8'h40;  // '@'
	localparam logic [CHAR_W-1:0] CH_END   = 8'h23;  // '#'
	localparam logic [CHAR_W-1:0] CH_SEP   = 8'h2C;  // ','
	localparam logic [CHAR_W-1:0] CH_LO    = 8'h61;  // 'a'
	localparam logic [CHAR_W-1:0] CH_HI    = 8'h64;  // 'd'
	localparam logic [ARG_W-1:0]  CH_ZERO  = 32'h30; // '0'

endpackage

>>> rtl/core/ascii_command_frame_parser.sv
// Top level of the ASCII command frame parser: input register, frame state
// and result register. Depends on acfp_pkg.
//
//  Channel   Dir  Payload (low bit first)                      Handshake
//  s_axis    in   rx_char[7:0]                                 tvalid/tready
//  m_axis    out  cmd_code[1:0], arg_first[33:2],              tvalid/tready
//                 arg_second[65:34], zero pad [71:66]
//
// One character is taken every cycle while no stalled result holds the input
// register; each is held in the input register, then folded into the frame
// state; a completed frame loads the result register at the edge that folds
// its '#', so its result shows after that '#' has passed the input register.
// Reset clears all frame state; no result is pending after reset. A stalled
// result holds the input register; the input side keeps accepting while the
// result register is empty or being drained.
module ascii_command_frame_parser
	import acfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [CHAR_W-1:0]  s_axis_tdata,   // rx_char[7:0]
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [OUT_T_W-1:0] m_axis_tdata    // cmd_code, arg_first, arg_second, pad
);

	// Input register.
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;

	// Frame state.
	logic              in_frame_q;
	logic [CNT_W-1:0]  char_count_q;
	logic [CHAR_W-1:0] cmd_letter_q;
	logic              sep_ok_q;
	logic              in_second_q;
	logic [ARG_W-1:0]  acc_first_q;
	logic [ARG_W-1:0]  acc_second_q;

	// Result register.
	logic              out_valid_q;
	logic [CMD_W-1:0]  cmd_code_q;
	logic [ARG_W-1:0]  arg_first_q;
	logic [ARG_W-1:0]  arg_second_q;

	logic              advance;
	logic              proc;
	logic              frame_ok;
	logic              is_start;
	logic              is_end;
	logic              is_sep;
	logic [ARG_W-1:0]  fold_first;
	logic [ARG_W-1:0]  fold_second;
	logic [CHAR_W-1:0] letter_off;

	// The stage moves whenever the result register is free or being emptied.
	assign advance       = !out_valid_q || m_axis_tready;
	assign proc          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	assign is_start = (char_s1 == CH_START);
	assign is_end   = (char_s1 == CH_END);
	assign is_sep   = (char_s1 == CH_SEP);

	// A frame is good when it has a command letter a to d and a comma after it.
	assign frame_ok = (char_count_q >= CNT_W'(2)) && (cmd_letter_q >= CH_LO) &&
		(cmd_letter_q <= CH_HI) && sep_ok_q;
	assign letter_off = cmd_letter_q - CH_LO;

	// Decimal fold acc*10 + c - '0', wrapping at the accumulator width.
	assign fold_first = {acc_first_q[ARG_W-4:0], 3'b000} +
		{acc_first_q[ARG_W-2:0], 1'b0} + ARG_W'(char_s1) - CH_ZERO;
	assign fold_second = {acc_second_q[ARG_W-4:0], 3'b000} +
		{acc_second_q[ARG_W-2:0], 1'b0} + ARG_W'(char_s1) - CH_ZERO;

	// Input register loads on every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
		end
	end

	// Frame state update for the character in the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			char_count_q <= '0;
			cmd_letter_q <= '0;
			sep_ok_q     <= 1'b0;
			in_second_q  <= 1'b0;
			acc_first_q  <= '0;
			acc_second_q <= '0;
		end else if (proc) begin
			if (!in_frame_q || is_start || is_end ||
				(char_count_q >= CNT_W'(MAX_FRAME_CHARS))) begin
				// Start, restart, end or overflow: the frame state starts over.
				in_frame_q   <= is_start;
				char_count_q <= '0;
				cmd_letter_q <= '0;
				sep_ok_q     <= 1'b0;
				in_second_q  <= 1'b0;
				acc_first_q  <= '0;
				acc_second_q <= '0;
			end else begin
				char_count_q <= char_count_q + CNT_W'(1);
				if (char_count_q == '0) begin
					cmd_letter_q <= char_s1;
				end else if (char_count_q == CNT_W'(1)) begin
					sep_ok_q <= is_sep;
				end else if (!in_second_q && is_sep) begin
					in_second_q <= 1'b1;
				end else if (in_second_q) begin
					acc_second_q <= fold_second;
				end else begin
					acc_first_q <= fold_first;
				end
			end
		end
	end

	// Result register: loads on a good closing '#', drains on the handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= proc && in_frame_q && is_end && frame_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && in_frame_q && is_end && frame_ok) begin
			cmd_code_q   <= letter_off[CMD_W-1:0];
			arg_first_q  <= acc_first_q;
			arg_second_q <= acc_second_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_T_W - OUT_W)'(0), arg_second_q, arg_first_q, cmd_code_q};

endmodule

>>> rtl/core/acfp_checker.sv
// Port-level checker for the ASCII command frame parser, with its bind.
// Depends on acfp_pkg and the ports of ascii_command_frame_parser.
module acfp_checker
	import acfp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic [CHAR_W-1:0]  s_axis_tdata,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [OUT_T_W-1:0] m_axis_tdata
);

	// A stalled result keeps its request and its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or dropped");

	// A new result only follows a frame end accepted through the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
		$past(s_axis_tvalid && s_axis_tready && (s_axis_tdata == CH_END), 2))
		else $error("result without a preceding frame end");

	// With no result pending the input side never stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while result register is empty");

	// The pad bits above the packed result stay zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_T_W-1:OUT_W] == '0))
		else $error("result pad bits not zero");

endmodule

bind ascii_command_frame_parser acfp_checker u_acfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
